FILE: hw/rtl/sgp_pkg.sv
package sgp_pkg;

	// Defaults for the top-level parameters
	localparam int WINDOW_MAX_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// Field widths
	localparam int COEF_W  = 18;   // Q2.16 coefficient
	localparam int WLEN_W  = 9;    // window length register
	localparam int POWER_W = 48;   // saturated power
	localparam int ACC_W   = 32;   // recurrence state

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] REG_COEFFICIENT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd256;

	// Job queue between the front and the engine
	localparam int JOB_FIFO_DEPTH = 2;

	// Engine status seen by the front and the job queue
	typedef struct packed {
		logic busy;   // a window is being evaluated
		logic pop;    // take the head job this cycle
	} eng_stat_t;

endpackage

FILE: hw/rtl/sgp_if.sv
interface sgp_sample_if #(
	parameter int SAMPLE_BITS = sgp_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          end_of_block;

	modport source (output valid, output sample, output end_of_block, input ready);
	modport sink (input valid, input sample, input end_of_block, output ready);
endinterface

interface sgp_power_if;
	import sgp_pkg::*;

	logic               valid;
	logic               ready;
	logic [POWER_W-1:0] power;

	modport source (output valid, output power, input ready);
	modport sink (input valid, input power, output ready);
endinterface

interface sgp_cfg_if;
	import sgp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/sgp_job_fifo.sv
module sgp_job_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = sgp_pkg::JOB_FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	import sgp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(DEPTH)))
		else $error("job queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue popped while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("job queue count out of range");
`endif

endmodule

FILE: hw/rtl/sgp_front.sv
module sgp_front #(
	parameter int WINDOW_MAX  = sgp_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = sgp_pkg::SAMPLE_BITS_DEF,
	localparam int PTR_W = $clog2(WINDOW_MAX),
	localparam int CNT_W = $clog2(WINDOW_MAX + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sgp_sample_if.sink                    samples,
	input  logic [sgp_pkg::WLEN_W-1:0]    window_length,
	input  sgp_pkg::eng_stat_t            eng_stat,
	input  logic                          job_empty,
	output logic                          job_push,
	output logic [PTR_W-1:0]              job_start,
	output logic [CNT_W-1:0]              job_len,
	input  logic [PTR_W-1:0]              rd_addr,
	output logic signed [SAMPLE_BITS-1:0] rd_data
);
	import sgp_pkg::*;

	localparam int EXT_W = CNT_W + 1;

	logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] rd_data_q;
	logic [PTR_W-1:0]              wr_ptr_q;
	logic [PTR_W-1:0]              wr_ptr_next;
	logic [CNT_W-1:0]              fill_q;
	logic [CNT_W-1:0]              fill_next;
	logic [CNT_W-1:0]              eff_len;
	logic [EXT_W-1:0]              ptr_ext;
	logic [EXT_W-1:0]              len_ext;
	logic [EXT_W-1:0]              start_wide;
	logic                          accept;

	// Hold new samples while a window is queued or under evaluation: the
	// engine reads ring entries that the next write would replace.
	assign samples.ready = job_empty && !eng_stat.busy;
	assign accept        = samples.valid && samples.ready;

	always_comb begin
		if (window_length == '0) begin
			eff_len = CNT_W'(1);
		end else if (int'(window_length) > WINDOW_MAX) begin
			eff_len = CNT_W'(WINDOW_MAX);
		end else begin
			eff_len = CNT_W'(window_length);
		end
	end

	assign wr_ptr_next = (wr_ptr_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign fill_next   = (fill_q == CNT_W'(WINDOW_MAX)) ? fill_q : fill_q + 1'b1;

	// Oldest sample of the window ending at the entry just written
	always_comb begin
		ptr_ext = EXT_W'(wr_ptr_next);
		len_ext = EXT_W'(eff_len);
		if (ptr_ext >= len_ext) begin
			start_wide = ptr_ext - len_ext;
		end else begin
			start_wide = ptr_ext + EXT_W'(WINDOW_MAX) - len_ext;
		end
	end

	assign job_push  = accept && (fill_next >= eff_len);
	assign job_start = start_wide[PTR_W-1:0];
	assign job_len   = eff_len;
	assign rd_data   = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else if (accept) begin
			wr_ptr_q <= wr_ptr_next;
			fill_q   <= samples.end_of_block ? '0 : fill_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ring[wr_ptr_q] <= samples.sample;
		end
		rd_data_q <= ring[rd_addr];
	end

`ifndef ASSERT_OFF
	a_eob_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.end_of_block) |=> (fill_q == '0))
		else $error("fill count not restarted after end of block");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_MAX))
		else $error("fill count beyond ring depth");
	a_hold_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> !samples.ready)
		else $error("front open while a window is pending");
`endif

endmodule

FILE: hw/rtl/sgp_engine.sv
module sgp_engine #(
	parameter int WINDOW_MAX  = sgp_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = sgp_pkg::SAMPLE_BITS_DEF,
	localparam int PTR_W = $clog2(WINDOW_MAX),
	localparam int CNT_W = $clog2(WINDOW_MAX + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [sgp_pkg::COEF_W-1:0]  coefficient,
	input  logic                               job_valid,
	input  logic [PTR_W-1:0]                   job_start,
	input  logic [CNT_W-1:0]                   job_len,
	output sgp_pkg::eng_stat_t                 eng_stat,
	output logic [PTR_W-1:0]                   rd_addr,
	input  logic signed [SAMPLE_BITS-1:0]      rd_data,
	sgp_power_if.source                        powers
);
	import sgp_pkg::*;

	localparam int PROD_W  = COEF_W + ACC_W;
	localparam int T_W     = PROD_W - 16;
	localparam int SUM_W   = T_W + 2;
	localparam int SQ_W    = 2 * ACC_W;
	localparam int CROSS_W = T_W + ACC_W;
	localparam int DIFF_W  = CROSS_W + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PRIME = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_FIN1  = 3'd3;
	localparam logic [2:0] ST_FIN2  = 3'd4;
	localparam logic [2:0] ST_FIN3  = 3'd5;

	logic [2:0]                state_q;
	logic [PTR_W-1:0]          rd_addr_q;
	logic [PTR_W-1:0]          rd_addr_next;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [ACC_W-1:0]   s1_q;
	logic signed [ACC_W-1:0]   s2_q;
	logic signed [T_W-1:0]     t2_q;
	logic signed [SQ_W-1:0]    sq1_q;
	logic signed [SQ_W-1:0]    sq2_q;
	logic signed [SQ_W:0]      sum_q;
	logic signed [CROSS_W-1:0] cross_q;
	logic [POWER_W-1:0]        pow_q;
	logic                      out_valid_q;

	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_rnd;
	logic signed [T_W-1:0]     t_round;
	logic signed [SUM_W-1:0]   s_sum;
	logic signed [ACC_W-1:0]   s_sat;
	logic signed [DIFF_W-1:0]  diff;
	logic [POWER_W-1:0]        power_val;
	logic                      out_free;
	logic                      load_out;

	assign eng_stat.busy = (state_q != ST_IDLE);
	assign eng_stat.pop  = (state_q == ST_IDLE) && job_valid;
	assign rd_addr       = rd_addr_q;
	assign rd_addr_next  = (rd_addr_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : rd_addr_q + 1'b1;

	// One recurrence step: round(c*s1) in Q2.16, ties up, then x + t - s2
	assign prod     = coefficient * s1_q;
	assign prod_rnd = prod + PROD_W'(32768);
	assign t_round  = T_W'(prod_rnd >>> 16);
	assign s_sum    = SUM_W'(rd_data) + SUM_W'(t_round) - SUM_W'(s2_q);

	always_comb begin
		if (s_sum[SUM_W-1:ACC_W-1] == '0 || s_sum[SUM_W-1:ACC_W-1] == '1) begin
			s_sat = s_sum[ACC_W-1:0];
		end else if (s_sum[SUM_W-1]) begin
			s_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			s_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	// Clamp below at zero, saturate above
	assign diff = DIFF_W'(sum_q) - DIFF_W'(cross_q);

	always_comb begin
		if (diff[DIFF_W-1]) begin
			power_val = '0;
		end else if (|diff[DIFF_W-2:POWER_W]) begin
			power_val = '1;
		end else begin
			power_val = diff[POWER_W-1:0];
		end
	end

	assign out_free = !out_valid_q || powers.ready;
	assign load_out = (state_q == ST_FIN3) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) state_q <= ST_PRIME;
				end
				ST_PRIME: state_q <= ST_RUN;
				ST_RUN: begin
					if (cnt_q == CNT_W'(1)) state_q <= ST_FIN1;
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: state_q <= ST_FIN3;
				ST_FIN3: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (powers.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_stat.pop) begin
			rd_addr_q <= job_start;
			cnt_q     <= job_len;
			s1_q      <= '0;
			s2_q      <= '0;
		end
		if (state_q == ST_PRIME) begin
			rd_addr_q <= rd_addr_next;
		end
		if (state_q == ST_RUN) begin
			rd_addr_q <= rd_addr_next;
			cnt_q     <= cnt_q - 1'b1;
			s2_q      <= s1_q;
			s1_q      <= s_sat;
		end
		if (state_q == ST_FIN1) begin
			t2_q  <= t_round;
			sq1_q <= s1_q * s1_q;
			sq2_q <= s2_q * s2_q;
		end
		if (state_q == ST_FIN2) begin
			sum_q   <= (SQ_W + 1)'(sq1_q) + (SQ_W + 1)'(sq2_q);
			cross_q <= t2_q * s2_q;
		end
		if (load_out) begin
			pow_q <= power_val;
		end
	end

	assign powers.valid = out_valid_q;
	assign powers.power = pow_q;

`ifndef ASSERT_OFF
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (cnt_q != '0))
		else $error("recurrence running with no samples left");
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.pop |=> (state_q == ST_PRIME))
		else $error("popped job did not start");
	a_fin_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN1) |=> (state_q == ST_FIN2))
		else $error("power stages out of order");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN3))
		else $error("result raised outside the final stage");
`endif

endmodule

FILE: hw/rtl/sliding_goertzel_power_unit.sv
// Sliding-window Goertzel power unit.
//
// samples: sink of (sample, end_of_block) words. Each accepted word is stored
// in a ring of WINDOW_MAX entries. Once at least window_length words have
// arrived since reset or the last end_of_block, the word yields one power
// word on powers; earlier words yield nothing. end_of_block restarts the fill.
// cfg: register writes (index 0 coefficient Q2.16, index 1 window_length),
// always ready; write only while the unit is idle.
// A power word shows on powers after its job passes the job queue and the
// engine states PRIME, RUN (one step per word of the effective window),
// FIN1, FIN2 and FIN3. The engine runs one multiply-accumulate per cycle
// over the ring's read port. A word that yields a result keeps samples
// closed until its power word is loaded; a word with no result does not.
// Reset clears the ring pointer, fill count, coefficient (0) and window
// length (256); ring contents are not cleared.
// When powers stalls, the finished word waits in the output register and the
// engine holds its next result; samples stays closed until the engine frees.
module sliding_goertzel_power_unit #(
	parameter int WINDOW_MAX  = sgp_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = sgp_pkg::SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sgp_sample_if.sink   samples,
	sgp_power_if.source  powers,
	sgp_cfg_if.sink      cfg
);
	import sgp_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int JOB_W = PTR_W + CNT_W;

	// Configuration registers
	logic signed [COEF_W-1:0] coef_q;
	logic [WLEN_W-1:0]        wlen_q;

	// Front to queue to engine
	eng_stat_t                     eng_stat;
	logic                          job_push;
	logic [PTR_W-1:0]              job_start;
	logic [CNT_W-1:0]              job_len;
	logic                          job_empty;
	logic [JOB_W-1:0]              job_head;
	logic [PTR_W-1:0]              rd_addr;
	logic signed [SAMPLE_BITS-1:0] rd_data;

	// Register writes are always accepted
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			wlen_q <= WLEN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_COEFFICIENT:   coef_q <= COEF_W'(cfg.data);
				REG_WINDOW_LENGTH: wlen_q <= cfg.data[WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: store samples, track fill, issue one job per result
	sgp_front #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.samples       (samples),
		.window_length (wlen_q),
		.eng_stat      (eng_stat),
		.job_empty     (job_empty),
		.job_push      (job_push),
		.job_start     (job_start),
		.job_len       (job_len),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	// Job queue: start position and length of each window to evaluate
	sgp_job_fifo #(
		.W     (JOB_W),
		.DEPTH (JOB_FIFO_DEPTH)
	) u_job_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data ({job_start, job_len}),
		.pop       (eng_stat.pop),
		.pop_data  (job_head),
		.empty     (job_empty)
	);

	// Engine: run the recurrence over the window, then form the power
	sgp_engine #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.coefficient (coef_q),
		.job_valid   (!job_empty),
		.job_start   (job_head[JOB_W-1:CNT_W]),
		.job_len     (job_head[CNT_W-1:0]),
		.eng_stat    (eng_stat),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.powers      (powers)
	);

endmodule
